@@ rtl/wphg_pkg.sv @@
// wphg_pkg: shared types, codes and constants of the waypoint heading guidance block
// no dependencies; used by the channel interfaces and the top level
package wphg_pkg;

	typedef logic signed [15:0] coord_t;
	typedef logic signed [15:0] angle_t;
	typedef logic [1:0]         cmd_t;
	typedef logic [5:0]         route_t;

	// request types
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_POSE = 1'b1;

	// drive commands
	localparam cmd_t CMD_FORWARD  = 2'd0;
	localparam cmd_t CMD_BACKWARD = 2'd1;
	localparam cmd_t CMD_LEFT     = 2'd2;
	localparam cmd_t CMD_RIGHT    = 2'd3;

	// configuration register indexes
	localparam int  CFG_IDX_W          = 1;
	localparam int  CFG_DATA_W         = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DISTANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_LENGTH   = 1'd1;

	localparam logic [15:0] CLOSE_DISTANCE_RST = 16'd461;
	localparam route_t      ROUTE_LENGTH_RST   = 6'd22;

	// sector edges: 30 and 150 degrees as 16-bit binary angles
	localparam angle_t SECTOR_NEAR = 16'sd5461;
	localparam angle_t SECTOR_FAR  = 16'sd27307;

	localparam int ATAN_ENTRIES = 24;

	// atan(2^-i) as 32-bit binary angles
	function automatic logic [31:0] atan_step(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h2000_0000;
			5'd1:  a = 32'h12E4_051E;
			5'd2:  a = 32'h09FB_385B;
			5'd3:  a = 32'h0511_11D4;
			5'd4:  a = 32'h028B_0D43;
			5'd5:  a = 32'h0145_D7E1;
			5'd6:  a = 32'h00A2_F61E;
			5'd7:  a = 32'h0051_7C55;
			5'd8:  a = 32'h0028_BE53;
			5'd9:  a = 32'h0014_5F2F;
			5'd10: a = 32'h000A_2F98;
			5'd11: a = 32'h0005_17CC;
			5'd12: a = 32'h0002_8BE6;
			5'd13: a = 32'h0001_45F3;
			5'd14: a = 32'h0000_A2FA;
			5'd15: a = 32'h0000_517D;
			5'd16: a = 32'h0000_28BE;
			5'd17: a = 32'h0000_145F;
			5'd18: a = 32'h0000_0A30;
			5'd19: a = 32'h0000_0518;
			5'd20: a = 32'h0000_028C;
			5'd21: a = 32'h0000_0146;
			5'd22: a = 32'h0000_00A3;
			5'd23: a = 32'h0000_0051;
			default: a = 32'h0000_0000;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/wphg_intf.sv @@
// wphg_req_if and wphg_res_if: valid/ready channels for requests and results
// depends on wphg_pkg for payload types
interface wphg_req_if;
	logic            valid;
	logic            ready;
	logic            req_type;
	logic [4:0]      wp_slot;
	wphg_pkg::coord_t coord_x;
	wphg_pkg::coord_t coord_y;
	wphg_pkg::angle_t heading;

	modport source(output valid, req_type, wp_slot, coord_x, coord_y, heading, input ready);
	modport sink(input valid, req_type, wp_slot, coord_x, coord_y, heading, output ready);
endinterface

interface wphg_res_if;
	logic             valid;
	logic             ready;
	wphg_pkg::route_t route_pos;
	wphg_pkg::coord_t goal_x;
	wphg_pkg::coord_t goal_y;
	wphg_pkg::angle_t bearing;
	wphg_pkg::angle_t heading_error;
	wphg_pkg::cmd_t   command;
	logic             finished;

	modport source(output valid, route_pos, goal_x, goal_y, bearing, heading_error, command,
		finished, input ready);
	modport sink(input valid, route_pos, goal_x, goal_y, bearing, heading_error, command,
		finished, output ready);
endinterface

@@ rtl/waypoint_heading_guidance.sv @@
// waypoint_heading_guidance: route follower with arrival check and cordic bearing, on wphg_pkg
// and the channel interfaces in wphg_intf.sv
// load request: written to the store, no result; pose request: arrival check, then the
// CORDIC_STEPS passes of the shift-add unit, then rounding and sector pick; no y offset
// skips the passes, the last waypoint or a finished route skips them too; one at a time
// arst_n clears position, finished flag and sequencer, loads register defaults; store not cleared
module waypoint_heading_guidance #(
	parameter int MAX_WAYPOINTS = 32,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	wphg_req_if.sink                           req,
	wphg_res_if.source                         res,
	input  logic                               cfg_we,
	input  logic [wphg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wphg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W  = $clog2(MAX_WAYPOINTS);
	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FETCH  = 4'd1;   // store data ready, offset to target
	localparam logic [3:0] S_SQX    = 4'd2;   // dx squared
	localparam logic [3:0] S_SQY    = 4'd3;   // dy squared
	localparam logic [3:0] S_SQR    = 4'd4;   // radius squared, sum of offsets
	localparam logic [3:0] S_CMP    = 4'd5;   // arrival check, advance
	localparam logic [3:0] S_REREAD = 4'd6;   // store read at the new position
	localparam logic [3:0] S_SETUP  = 4'd7;   // cordic start vector
	localparam logic [3:0] S_CORD   = 4'd8;   // one rotation per cycle
	localparam logic [3:0] S_FIN    = 4'd9;   // rounding, wrap, sector
	localparam logic [3:0] S_EMIT   = 4'd10;  // hand result to the output register

	logic [3:0] state_q;

	// configuration
	logic [15:0]      close_q;
	wphg_pkg::route_t route_len_q;
	wphg_pkg::route_t len_eff;

	// route progress
	wphg_pkg::route_t route_idx_q;
	logic             done_q;

	// waypoint store: y in the high half, x in the low half
	logic [31:0]      wp_mem [MAX_WAYPOINTS];
	logic [31:0]      rd_q;
	logic             mem_we;

	// pose request
	wphg_pkg::coord_t px_q, py_q;
	wphg_pkg::angle_t hd_q;

	// distance check
	logic signed [16:0] dx_q, dy_q;
	logic signed [16:0] sq_op;
	logic signed [33:0] sq_full;
	logic [31:0]        p_q;
	logic [32:0]        acc_q;

	// cordic unit
	logic signed [27:0] x_q, y_q;
	logic [31:0]        z_q;
	logic [STEP_W-1:0]  step_q;
	logic signed [27:0] xs, ys;
	logic [31:0]        atan_a;

	// target offset from the store word
	wphg_pkg::coord_t   tx, ty;
	logic signed [16:0] off_x, off_y;
	logic signed [16:0] abs_x, rot_y;
	logic signed [27:0] ext_x, ext_y;

	// result staging
	wphg_pkg::coord_t goal_x_q, goal_y_q;
	wphg_pkg::angle_t brg_q, err_q;
	wphg_pkg::cmd_t   cmd_q;
	logic [31:0]      z_round;
	wphg_pkg::angle_t brg_c, err_c;
	wphg_pkg::cmd_t   cmd_c;

	// output register
	logic             res_valid_q;
	wphg_pkg::route_t o_pos_q;
	wphg_pkg::coord_t o_gx_q, o_gy_q;
	wphg_pkg::angle_t o_brg_q, o_err_q;
	wphg_pkg::cmd_t   o_cmd_q;
	logic             o_fin_q;

	logic req_fire, emit_go;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign emit_go   = (state_q == S_EMIT) && (!res_valid_q || res.ready);

	// effective route length: zero reads as one, capped at the store depth
	always_comb begin
		if (route_len_q == 6'd0) begin
			len_eff = 6'd1;
		end else if (int'(route_len_q) > MAX_WAYPOINTS) begin
			len_eff = 6'(MAX_WAYPOINTS);
		end else begin
			len_eff = route_len_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q     <= wphg_pkg::CLOSE_DISTANCE_RST;
			route_len_q <= wphg_pkg::ROUTE_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wphg_pkg::CFG_CLOSE_DISTANCE: close_q     <= cfg_data;
				wphg_pkg::CFG_ROUTE_LENGTH:   route_len_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// store: one write port for load requests, registered read at the route position
	assign mem_we = req_fire && (req.req_type == wphg_pkg::REQ_LOAD)
		&& (int'(req.wp_slot) < MAX_WAYPOINTS);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wp_mem[IDX_W'(req.wp_slot)] <= {req.coord_y, req.coord_x};
		end
		rd_q <= wp_mem[IDX_W'(route_idx_q)];
	end

	// offset from pose to the waypoint just read
	assign tx    = rd_q[15:0];
	assign ty    = rd_q[31:16];
	assign off_x = 17'(tx) - 17'(px_q);
	assign off_y = 17'(ty) - 17'(py_q);

	// fold the left half-plane onto the right, start at half a turn
	assign abs_x = off_x[16] ? -off_x : off_x;
	assign rot_y = off_x[16] ? -off_y : off_y;
	assign ext_x = 28'(abs_x);
	assign ext_y = 28'(rot_y);

	// shared squarer for dx, dy and the arrival radius
	always_comb begin
		case (state_q)
			S_SQX:   sq_op = dx_q;
			S_SQY:   sq_op = dy_q;
			default: sq_op = $signed({1'b0, close_q});
		endcase
	end
	assign sq_full = sq_op * sq_op;

	// cordic rotation: floor shifts of the current vector
	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign atan_a = wphg_pkg::atan_step(5'(step_q));

	// round the 32-bit angle to 16 bits, wrap the error, pick the sector
	assign z_round = z_q + 32'h0000_8000;
	assign brg_c   = z_round[31:16];
	assign err_c   = brg_c - hd_q;

	always_comb begin
		if (err_c > -wphg_pkg::SECTOR_NEAR && err_c < wphg_pkg::SECTOR_NEAR) begin
			cmd_c = wphg_pkg::CMD_FORWARD;
		end else if (err_c >= -wphg_pkg::SECTOR_FAR && err_c <= -wphg_pkg::SECTOR_NEAR) begin
			cmd_c = wphg_pkg::CMD_RIGHT;
		end else if (err_c >= wphg_pkg::SECTOR_NEAR && err_c <= wphg_pkg::SECTOR_FAR) begin
			cmd_c = wphg_pkg::CMD_LEFT;
		end else begin
			cmd_c = wphg_pkg::CMD_BACKWARD;
		end
	end

	// sequencer and route progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			route_idx_q <= '0;
			done_q      <= 1'b0;
			step_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire && req.req_type == wphg_pkg::REQ_POSE) begin
						// route shortened below the current position
						if (!done_q && route_idx_q >= len_eff) begin
							done_q <= 1'b1;
						end
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= done_q ? S_EMIT : S_SQX;
				end
				S_SQX: begin
					state_q <= S_SQY;
				end
				S_SQY: begin
					state_q <= S_SQR;
				end
				S_SQR: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (acc_q < {1'b0, p_q}) begin
						route_idx_q <= route_idx_q + 6'd1;
						if (route_idx_q + 6'd1 >= len_eff) begin
							done_q <= 1'b1;
						end
					end
					state_q <= S_REREAD;
				end
				S_REREAD: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					step_q <= '0;
					if (done_q) begin
						state_q <= S_EMIT;
					end else if (off_y == 17'sd0) begin
						// on target or straight along x: no rotation needed
						state_q <= S_FIN;
					end else begin
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			px_q <= req.coord_x;
			py_q <= req.coord_y;
			hd_q <= req.heading;
		end
		case (state_q)
			S_FETCH: begin
				dx_q <= off_x;
				dy_q <= off_y;
			end
			S_SQX: begin
				p_q <= sq_full[31:0];
			end
			S_SQY: begin
				p_q   <= sq_full[31:0];
				acc_q <= {1'b0, p_q};
			end
			S_SQR: begin
				p_q   <= sq_full[31:0];
				acc_q <= acc_q + {1'b0, p_q};
			end
			S_SETUP: begin
				goal_x_q <= tx;
				goal_y_q <= ty;
				x_q      <= ext_x <<< 8;
				y_q      <= ext_y <<< 8;
				// a zero offset has bearing zero even though it is not folded
				z_q      <= off_x[16] ? 32'h8000_0000 : 32'h0000_0000;
			end
			S_CORD: begin
				if (y_q > 28'sd0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_a;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_a;
				end
			end
			S_FIN: begin
				brg_q <= brg_c;
				err_q <= err_c;
				cmd_q <= cmd_c;
			end
			default: ;
		endcase
	end

	// output register: holds one result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			if (done_q) begin
				o_pos_q <= len_eff;
				o_gx_q  <= '0;
				o_gy_q  <= '0;
				o_brg_q <= '0;
				o_err_q <= '0;
				o_cmd_q <= wphg_pkg::CMD_FORWARD;
				o_fin_q <= 1'b1;
			end else begin
				o_pos_q <= route_idx_q;
				o_gx_q  <= goal_x_q;
				o_gy_q  <= goal_y_q;
				o_brg_q <= brg_q;
				o_err_q <= err_q;
				o_cmd_q <= cmd_q;
				o_fin_q <= 1'b0;
			end
		end
	end

	assign res.valid         = res_valid_q;
	assign res.route_pos     = o_pos_q;
	assign res.goal_x        = o_gx_q;
	assign res.goal_y        = o_gy_q;
	assign res.bearing       = o_brg_q;
	assign res.heading_error = o_err_q;
	assign res.command       = o_cmd_q;
	assign res.finished      = o_fin_q;

endmodule
